@@ src/ztt_pkg.sv @@
// Shared types and constants for the transposition table block.
// Used by the controller, the datapath and the top level; no dependencies.
package ztt_pkg;

  // Default geometry.
  localparam int DEF_BOARD_SIZE = 15;
  localparam int DEF_INDEX_BITS = 12;

  // Command codes; codes 5 to 7 do nothing.
  typedef enum logic [2:0] {
    CMD_LOAD   = 3'd0,
    CMD_CLEAR  = 3'd1,
    CMD_TOGGLE = 3'd2,
    CMD_LOOKUP = 3'd3,
    CMD_STORE  = 3'd4
  } cmd_t;

  // Entry kinds.
  localparam logic [1:0] KIND_EXACT = 2'd0;
  localparam logic [1:0] KIND_LOWER = 2'd1;
  localparam logic [1:0] KIND_UPPER = 2'd2;

  // One stored entry: valid flag, kind, eval and depth.
  typedef struct packed {
    logic               valid;
    logic [1:0]         kind;
    logic signed [15:0] eval;
    logic [7:0]         depth;
  } entry_info_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // item accepted this cycle: latch fields, issue reads
    logic exec;     // read data ready: update state and write result
    logic clr;      // reset sweep: clear one entry of the valid store
  } ztt_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last; // sweep is at its final entry
  } ztt_sts_t;

endpackage

@@ src/zobrist_transposition_table.sv @@
// Top level of the Zobrist-keyed transposition table.
// Instantiates ztt_ctrl and ztt_dpath; depends on ztt_pkg.
//
//   Channel   Handshake          Ports
//   input     start, busy        in_cmd .. in_table_sel
//   result    out_valid strobe   out_hit, out_value, out_running_short, out_running_long
//
// An item is accepted at a clock edge with start high and busy low. The key
// and entry memories are read at that edge; the next cycle executes the item,
// and its result is strobed in the cycle after that, when a new item may
// already be accepted.
// After reset, busy stays high while the entry valid store is cleared one
// entry per cycle.
// The receiver cannot stall; each result is shown for exactly one cycle.
module zobrist_transposition_table
  import ztt_pkg::*;
#(
  parameter int BOARD_SIZE = DEF_BOARD_SIZE,
  parameter int INDEX_BITS = DEF_INDEX_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_cmd,
  input  logic               in_color,
  input  logic [3:0]         in_row,
  input  logic [3:0]         in_col,
  input  logic [31:0]        in_key_short,
  input  logic [63:0]        in_key_long,
  input  logic signed [15:0] in_alpha,
  input  logic signed [15:0] in_beta,
  input  logic [7:0]         in_depth,
  input  logic [1:0]         in_entry_kind,
  input  logic signed [15:0] in_eval,
  input  logic               in_table_sel,
  output logic               out_valid,
  output logic               out_hit,
  output logic signed [15:0] out_value,
  output logic [31:0]        out_running_short,
  output logic [63:0]        out_running_long
);

  ztt_ctl_t ctl;
  ztt_sts_t sts;

  // Sequencing of each item and of the reset sweep.
  ztt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  // Memories, running keys and result registers.
  ztt_dpath #(
    .BOARD_SIZE (BOARD_SIZE),
    .INDEX_BITS (INDEX_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .sts               (sts),
    .in_cmd            (in_cmd),
    .in_color          (in_color),
    .in_row            (in_row),
    .in_col            (in_col),
    .in_key_short      (in_key_short),
    .in_key_long       (in_key_long),
    .in_alpha          (in_alpha),
    .in_beta           (in_beta),
    .in_depth          (in_depth),
    .in_entry_kind     (in_entry_kind),
    .in_eval           (in_eval),
    .in_table_sel      (in_table_sel),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_value         (out_value),
    .out_running_short (out_running_short),
    .out_running_long  (out_running_long)
  );

endmodule

@@ src/ztt_ctrl.sv @@
// Controller state machine for the transposition table block.
// Depends on ztt_pkg for the command and status structs.
module ztt_ctrl
  import ztt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  ztt_sts_t sts,
  output ztt_ctl_t ctl,
  output logic     busy
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r;
  logic   busy_r;

  // Commands decoded from the current state.
  always_comb begin
    ctl.capture = (state_r == ST_IDLE) && start;
    ctl.exec    = (state_r == ST_EXEC);
    ctl.clr     = (state_r == ST_CLEAR);
  end

  assign busy = busy_r;

  // State and the registered busy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      busy_r  <= 1'b1;
    end else begin
      case (state_r)
        ST_CLEAR: begin
          if (sts.clr_last) begin
            state_r <= ST_IDLE;
            busy_r  <= 1'b0;
          end
        end
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_EXEC;
            busy_r  <= 1'b1;
          end
        end
        ST_EXEC: begin
          state_r <= ST_IDLE;
          busy_r  <= 1'b0;
        end
        default: begin
          state_r <= ST_CLEAR;
          busy_r  <= 1'b1;
        end
      endcase
    end
  end

endmodule

@@ src/ztt_dpath.sv @@
// Datapath of the transposition table: key stores, entry stores,
// running keys and result registers. Depends on ztt_pkg.
module ztt_dpath
  import ztt_pkg::*;
#(
  parameter int BOARD_SIZE = DEF_BOARD_SIZE,
  parameter int INDEX_BITS = DEF_INDEX_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ztt_ctl_t           ctl,
  output ztt_sts_t           sts,
  input  logic [2:0]         in_cmd,
  input  logic               in_color,
  input  logic [3:0]         in_row,
  input  logic [3:0]         in_col,
  input  logic [31:0]        in_key_short,
  input  logic [63:0]        in_key_long,
  input  logic signed [15:0] in_alpha,
  input  logic signed [15:0] in_beta,
  input  logic [7:0]         in_depth,
  input  logic [1:0]         in_entry_kind,
  input  logic signed [15:0] in_eval,
  input  logic               in_table_sel,
  output logic               out_valid,
  output logic               out_hit,
  output logic signed [15:0] out_value,
  output logic [31:0]        out_running_short,
  output logic [63:0]        out_running_long
);

  localparam int CELLS     = BOARD_SIZE * BOARD_SIZE;
  localparam int KEY_DEPTH = 2 * CELLS;
  localparam int KADDR_W   = $clog2(KEY_DEPTH);
  localparam int SLOT_W    = INDEX_BITS + 1;
  localparam int SLOTS     = 1 << SLOT_W;
  localparam int RC_W      = 5;

  localparam logic [KADDR_W-1:0] CELLS_K = KADDR_W'(CELLS);
  localparam logic [KADDR_W-1:0] SIZE_K  = KADDR_W'(BOARD_SIZE);
  localparam logic [RC_W-1:0]    SIZE_RC = RC_W'(BOARD_SIZE);

  // Memories.
  logic [31:0]  skey_mem [KEY_DEPTH];
  logic [63:0]  lkey_mem [KEY_DEPTH];
  logic [63:0]  csum_mem [SLOTS];
  entry_info_t  info_mem [SLOTS];

  // Latched item fields.
  cmd_t               cmd_r;
  logic [KADDR_W-1:0] kaddr_r;
  logic               kok_r;
  logic [31:0]        key_short_r;
  logic [63:0]        key_long_r;
  logic signed [15:0] alpha_r;
  logic signed [15:0] beta_r;
  logic [7:0]         depth_r;
  logic [1:0]         kind_r;
  logic signed [15:0] eval_r;
  logic [SLOT_W-1:0]  slot_r;

  // Registered read data.
  logic [31:0] skey_rd_r;
  logic [63:0] lkey_rd_r;
  logic [63:0] csum_rd_r;
  entry_info_t info_rd_r;

  // Running keys, sweep counter and result registers.
  logic [31:0]        cur_short_r;
  logic [63:0]        cur_long_r;
  logic [SLOT_W-1:0]  clr_cnt_r;
  logic               valid_r;
  logic               hit_r;
  logic signed [15:0] value_r;

  logic [KADDR_W-1:0] kaddr_nxt;
  logic               kok_nxt;
  logic [SLOT_W-1:0]  slot_nxt;
  logic               hit_c;

  // Key address from color, row and column, with the on-board check.
  always_comb begin
    kaddr_nxt = (in_color ? CELLS_K : '0) + KADDR_W'(in_row) * SIZE_K + KADDR_W'(in_col);
    kok_nxt   = ({1'b0, in_row} < SIZE_RC) && ({1'b0, in_col} < SIZE_RC);
    slot_nxt  = {in_table_sel, cur_short_r[INDEX_BITS-1:0]};
  end

  // Latch the item when it is accepted.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r       <= cmd_t'(in_cmd);
      kaddr_r     <= kaddr_nxt;
      kok_r       <= kok_nxt;
      key_short_r <= in_key_short;
      key_long_r  <= in_key_long;
      alpha_r     <= in_alpha;
      beta_r      <= in_beta;
      depth_r     <= in_depth;
      kind_r      <= in_entry_kind;
      eval_r      <= in_eval;
      slot_r      <= slot_nxt;
    end
  end

  // Key stores: read on accept, written by a load.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      skey_rd_r <= skey_mem[kaddr_nxt];
      lkey_rd_r <= lkey_mem[kaddr_nxt];
    end
    if (ctl.exec && cmd_r == CMD_LOAD && kok_r) begin
      skey_mem[kaddr_r] <= key_short_r;
      lkey_mem[kaddr_r] <= key_long_r;
    end
  end

  // Checksum store: read on accept, written by a store.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      csum_rd_r <= csum_mem[slot_nxt];
    end
    if (ctl.exec && cmd_r == CMD_STORE) begin
      csum_mem[slot_r] <= cur_long_r;
    end
  end

  // Entry info store: cleared entry by entry by the reset sweep, then written by a store.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      info_rd_r <= info_mem[slot_nxt];
    end
    if (ctl.clr) begin
      info_mem[clr_cnt_r] <= '0;
    end else if (ctl.exec && cmd_r == CMD_STORE) begin
      info_mem[slot_r] <= '{valid: 1'b1, kind: kind_r, eval: eval_r, depth: depth_r};
    end
  end

  // Sweep counter for the reset clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (ctl.clr) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign sts.clr_last = &clr_cnt_r;

  // Hit test on the entry read for a lookup.
  always_comb begin
    hit_c = 1'b0;
    if (info_rd_r.valid && info_rd_r.depth >= depth_r && csum_rd_r == cur_long_r) begin
      case (info_rd_r.kind)
        KIND_EXACT: hit_c = 1'b1;
        KIND_LOWER: hit_c = info_rd_r.eval >= beta_r;
        KIND_UPPER: hit_c = info_rd_r.eval <= alpha_r;
        default:    hit_c = 1'b0;
      endcase
    end
  end

  // Running keys: cleared or toggled during execution.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_short_r <= '0;
      cur_long_r  <= '0;
    end else if (ctl.exec) begin
      case (cmd_r)
        CMD_CLEAR: begin
          cur_short_r <= '0;
          cur_long_r  <= '0;
        end
        CMD_TOGGLE: begin
          if (kok_r) begin
            cur_short_r <= cur_short_r ^ skey_rd_r;
            cur_long_r  <= cur_long_r ^ lkey_rd_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result registers: one strobe per executed item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      hit_r   <= (cmd_r == CMD_LOOKUP) && hit_c;
      value_r <= ((cmd_r == CMD_LOOKUP) && hit_c) ? info_rd_r.eval : '0;
    end
  end

  assign out_valid         = valid_r;
  assign out_hit           = hit_r;
  assign out_value         = value_r;
  assign out_running_short = cur_short_r;
  assign out_running_long  = cur_long_r;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for zobrist_transposition_table: directed and random commands,
// with an in-order mirror of the key store, the running keys and both entry tables.
// Depends on ztt_pkg and the RTL under src/; needs no files or arguments.
module testbench;
  import ztt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS = DEF_BOARD_SIZE * DEF_BOARD_SIZE;
  localparam int SLOTS = 1 << DEF_INDEX_BITS;
  localparam int RANDOM_ITEMS = 1300;
  localparam int CALM_ITEMS = 200;
  // The limit must outlast the valid-bit sweep after reset.
  localparam int STALL_LIMIT = 50000;
  localparam int DRAIN_CYCLES = 8;
  // Entry kind that is stored as given but never produces a hit.
  localparam logic [1:0] KIND_NONE = 2'd3;
  // Highest of the spare command codes, which leave all state alone.
  localparam logic [2:0] CMD_LAST_SPARE = 3'd7;

  // One command item as driven on the input ports.
  typedef struct {
    logic [2:0]         cmd;
    logic               color;
    logic [3:0]         row;
    logic [3:0]         col;
    logic [31:0]        key_short;
    logic [63:0]        key_long;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic [7:0]         depth;
    logic [1:0]         entry_kind;
    logic signed [15:0] eval;
    logic               table_sel;
  } tt_cmd_t;

  // One answer item as seen on the result ports.
  typedef struct {
    logic               hit;
    logic signed [15:0] value;
    logic [31:0]        running_short;
    logic [63:0]        running_long;
  } tt_answer_t;

  // A board square of one colour.
  typedef struct {
    logic       color;
    logic [3:0] row;
    logic [3:0] col;
  } square_t;

  // Mirror of the block's state; it predicts each answer and checks the results in order.
  class tt_mirror;
    bit [31:0]   short_keys [2*CELLS];
    bit [63:0]   long_keys [2*CELLS];
    bit [31:0]   cur_short;
    bit [63:0]   cur_long;
    bit [63:0]   slot_checksum [2*SLOTS];
    entry_info_t slot_info [2*SLOTS];
    tt_answer_t  pending_answers [$];
    int          failures;

    function new();
      foreach (slot_info[i]) slot_info[i] = '0;
    endfunction

    // Apply one accepted command and queue the answer it must produce.
    function void note_command(tt_cmd_t c);
      tt_answer_t  a;
      entry_info_t info;
      int          ci;
      int          si;
      a = '{default: '0};
      ci = int'(c.color) * CELLS + int'(c.row) * DEF_BOARD_SIZE + int'(c.col);
      si = int'(c.table_sel) * SLOTS + int'(cur_short[DEF_INDEX_BITS-1:0]);
      case (c.cmd)
        CMD_LOAD: begin
          if (c.row < DEF_BOARD_SIZE && c.col < DEF_BOARD_SIZE) begin
            short_keys[ci] = c.key_short;
            long_keys[ci] = c.key_long;
          end
        end
        CMD_CLEAR: begin
          cur_short = '0;
          cur_long = '0;
        end
        CMD_TOGGLE: begin
          if (c.row < DEF_BOARD_SIZE && c.col < DEF_BOARD_SIZE) begin
            cur_short ^= short_keys[ci];
            cur_long ^= long_keys[ci];
          end
        end
        CMD_LOOKUP: begin
          info = slot_info[si];
          if (info.valid && info.depth >= c.depth && slot_checksum[si] == cur_long) begin
            case (info.kind)
              KIND_EXACT: a.hit = 1'b1;
              KIND_LOWER: a.hit = ($signed(info.eval) >= $signed(c.beta));
              KIND_UPPER: a.hit = ($signed(info.eval) <= $signed(c.alpha));
              default:    a.hit = 1'b0;
            endcase
          end
          if (a.hit) a.value = info.eval;
        end
        CMD_STORE: begin
          slot_checksum[si] = cur_long;
          slot_info[si].valid = 1'b1;
          slot_info[si].kind = c.entry_kind;
          slot_info[si].eval = c.eval;
          slot_info[si].depth = c.depth;
        end
        default: ;
      endcase
      a.running_short = cur_short;
      a.running_long = cur_long;
      pending_answers.push_back(a);
    endfunction

    // Compare one strobed result with the oldest predicted answer.
    function void check_answer(tt_answer_t got);
      tt_answer_t exp_a;
      if (pending_answers.size() == 0) begin
        $error("result strobed with no item outstanding");
        failures++;
        return;
      end
      exp_a = pending_answers.pop_front();
      if (got.hit !== exp_a.hit) begin
        $error("hit mismatch: expected %0d, got %0d", exp_a.hit, got.hit);
        failures++;
      end
      if (got.value !== exp_a.value) begin
        $error("value mismatch: expected %0d, got %0d", exp_a.value, got.value);
        failures++;
      end
      if (got.running_short !== exp_a.running_short) begin
        $error("running_short mismatch: expected %h, got %h",
               exp_a.running_short, got.running_short);
        failures++;
      end
      if (got.running_long !== exp_a.running_long) begin
        $error("running_long mismatch: expected %h, got %h",
               exp_a.running_long, got.running_long);
        failures++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [2:0]         in_cmd;
  logic               in_color;
  logic [3:0]         in_row;
  logic [3:0]         in_col;
  logic [31:0]        in_key_short;
  logic [63:0]        in_key_long;
  logic signed [15:0] in_alpha;
  logic signed [15:0] in_beta;
  logic [7:0]         in_depth;
  logic [1:0]         in_entry_kind;
  logic signed [15:0] in_eval;
  logic               in_table_sel;
  logic               out_valid;
  logic               out_hit;
  logic signed [15:0] out_value;
  logic [31:0]        out_running_short;
  logic [63:0]        out_running_long;

  tt_mirror mirror = new();
  int       stall_cycles = 0;

  // Squares whose keys have been loaded, so that toggles never touch an unloaded key.
  bit       key_loaded [2][16][16];
  square_t  loaded_squares [$];
  // Moves made since the last clear, so that some toggles undo them.
  square_t  move_stack [$];

  zobrist_transposition_table i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_color          (in_color),
    .in_row            (in_row),
    .in_col            (in_col),
    .in_key_short      (in_key_short),
    .in_key_long       (in_key_long),
    .in_alpha          (in_alpha),
    .in_beta           (in_beta),
    .in_depth          (in_depth),
    .in_entry_kind     (in_entry_kind),
    .in_eval           (in_eval),
    .in_table_sel      (in_table_sel),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_value         (out_value),
    .out_running_short (out_running_short),
    .out_running_long  (out_running_long)
  );

  // Clock generation.
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Check every strobed result against the mirror.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      mirror.check_answer('{hit: out_hit, value: out_value,
                            running_short: out_running_short,
                            running_long: out_running_long});
    end
  end

  // Watchdog: end the run when nothing has moved on either side for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic bit on_board(square_t sq);
    return sq.row < DEF_BOARD_SIZE && sq.col < DEF_BOARD_SIZE;
  endfunction

  // An item with every field random; the builders below override what the command uses.
  function automatic tt_cmd_t noise_cmd(logic [2:0] cmd);
    tt_cmd_t c;
    c.cmd = cmd;
    c.color = 1'($urandom_range(0, 1));
    c.row = 4'($urandom_range(0, 15));
    c.col = 4'($urandom_range(0, 15));
    c.key_short = $urandom;
    c.key_long = {$urandom, $urandom};
    c.alpha = 16'($urandom);
    c.beta = 16'($urandom);
    c.depth = 8'($urandom);
    c.entry_kind = 2'($urandom);
    c.eval = 16'($urandom);
    c.table_sel = 1'($urandom_range(0, 1));
    return c;
  endfunction

  function automatic tt_cmd_t load_cmd(square_t sq, logic [31:0] ks, logic [63:0] kl);
    tt_cmd_t c;
    c = noise_cmd(CMD_LOAD);
    c.color = sq.color;
    c.row = sq.row;
    c.col = sq.col;
    c.key_short = ks;
    c.key_long = kl;
    return c;
  endfunction

  function automatic tt_cmd_t toggle_cmd(square_t sq);
    tt_cmd_t c;
    c = noise_cmd(CMD_TOGGLE);
    c.color = sq.color;
    c.row = sq.row;
    c.col = sq.col;
    return c;
  endfunction

  function automatic tt_cmd_t store_cmd(logic tsel, logic [1:0] kind,
                                        logic signed [15:0] ev, logic [7:0] dep);
    tt_cmd_t c;
    c = noise_cmd(CMD_STORE);
    c.table_sel = tsel;
    c.entry_kind = kind;
    c.eval = ev;
    c.depth = dep;
    return c;
  endfunction

  function automatic tt_cmd_t lookup_cmd(logic tsel, logic signed [15:0] lo,
                                         logic signed [15:0] hi, logic [7:0] dep);
    tt_cmd_t c;
    c = noise_cmd(CMD_LOOKUP);
    c.table_sel = tsel;
    c.alpha = lo;
    c.beta = hi;
    c.depth = dep;
    return c;
  endfunction

  // Drive one item and hold it until the block accepts it.
  task automatic issue(tt_cmd_t c);
    square_t sq;
    start <= 1'b1;
    in_cmd <= c.cmd;
    in_color <= c.color;
    in_row <= c.row;
    in_col <= c.col;
    in_key_short <= c.key_short;
    in_key_long <= c.key_long;
    in_alpha <= c.alpha;
    in_beta <= c.beta;
    in_depth <= c.depth;
    in_entry_kind <= c.entry_kind;
    in_eval <= c.eval;
    in_table_sel <= c.table_sel;
    @(posedge clk);
    while (busy) @(posedge clk);
    mirror.note_command(c);
    // Remember newly loaded squares as candidates for moves.
    sq = '{color: c.color, row: c.row, col: c.col};
    if (c.cmd == CMD_LOAD && on_board(sq) && !key_loaded[sq.color][sq.row][sq.col]) begin
      key_loaded[sq.color][sq.row][sq.col] = 1'b1;
      loaded_squares.push_back(sq);
    end
  endtask

  // A random sender gap, taken now and then when allowed.
  task automatic maybe_idle(bit allowed);
    if (allowed && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic tt_cmd_t random_load();
    square_t     sq;
    logic [31:0] ks;
    sq.color = 1'($urandom_range(0, 1));
    sq.row = ($urandom_range(0, 9) == 0) ? 4'd15 : 4'($urandom_range(0, DEF_BOARD_SIZE - 1));
    sq.col = ($urandom_range(0, 9) == 0) ? 4'd15 : 4'($urandom_range(0, DEF_BOARD_SIZE - 1));
    ks = $urandom;
    // Keys with clear index bits give positions that share a slot but not a checksum.
    if ($urandom_range(0, 3) == 0) ks[DEF_INDEX_BITS-1:0] = '0;
    return load_cmd(sq, ks, {$urandom, $urandom});
  endfunction

  // One random item: mostly move sequences with stores and lookups, plus some noise.
  task automatic random_step();
    tt_cmd_t     c;
    square_t     sq;
    int unsigned pick;
    logic [1:0]  kind;
    logic [7:0]  dep;
    pick = $urandom_range(0, 99);
    if (loaded_squares.size() < 12 || pick < 6) begin
      c = random_load();
    end else if (pick < 9) begin
      c = noise_cmd(CMD_CLEAR);
      move_stack.delete();
    end else if (pick < 36) begin
      if (move_stack.size() > 0 && $urandom_range(0, 1) == 1) begin
        sq = move_stack.pop_back();
      end else begin
        sq = loaded_squares[$urandom_range(0, loaded_squares.size() - 1)];
        move_stack.push_back(sq);
      end
      c = toggle_cmd(sq);
    end else if (pick < 38) begin
      sq.color = 1'($urandom_range(0, 1));
      sq.row = 4'($urandom_range(0, 15));
      sq.col = 4'd15;
      if ($urandom_range(0, 1) == 1) begin
        sq.col = sq.row;
        sq.row = 4'd15;
      end
      c = toggle_cmd(sq);
    end else if (pick < 62) begin
      kind = ($urandom_range(0, 19) == 0) ? KIND_NONE : 2'($urandom_range(0, 2));
      dep = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 8)) : 8'($urandom);
      c = store_cmd(1'($urandom_range(0, 1)), kind, 16'($urandom), dep);
    end else if (pick < 96) begin
      dep = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 8)) : 8'($urandom);
      c = lookup_cmd(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), dep);
    end else begin
      c = noise_cmd(3'($urandom_range(CMD_STORE + 1, CMD_LAST_SPARE)));
    end
    issue(c);
  endtask

  // Reset, directed items, random items, then drain and report.
  initial begin
    square_t sq_a;
    square_t sq_b;
    square_t sq_c;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_cmd <= CMD_CLEAR;
    in_color <= 1'b0;
    in_row <= '0;
    in_col <= '0;
    in_key_short <= '0;
    in_key_long <= '0;
    in_alpha <= '0;
    in_beta <= '0;
    in_depth <= '0;
    in_entry_kind <= KIND_EXACT;
    in_eval <= '0;
    in_table_sel <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    sq_a = '{color: 1'b0, row: 4'd0, col: 4'd0};
    sq_b = '{color: 1'b1, row: 4'(DEF_BOARD_SIZE - 1), col: 4'(DEF_BOARD_SIZE - 1)};
    sq_c = '{color: 1'b1, row: 4'd7, col: 4'd7};

    // Lookup of an entry never stored, and a spare command code.
    issue(lookup_cmd(1'b0, 16'sd0, 16'sd0, 8'd0));
    issue(noise_cmd(CMD_LAST_SPARE));

    // Loads at the board corners and outside the board.
    issue(load_cmd(sq_a, '1, '1));
    maybe_idle(1'b1);
    issue(load_cmd(sq_b, 32'h0000_0001, 64'h8000_0000_0000_0001));
    issue(load_cmd('{color: 1'b0, row: 4'd15, col: 4'd2}, $urandom, {$urandom, $urandom}));
    issue(load_cmd('{color: 1'b1, row: 4'd3, col: 4'd15}, $urandom, {$urandom, $urandom}));

    // Toggles on and off the board.
    issue(toggle_cmd(sq_a));
    issue(toggle_cmd('{color: 1'b1, row: 4'd15, col: 4'd15}));
    issue(toggle_cmd(sq_b));

    // Exact entry at the extremes of eval and depth.
    issue(store_cmd(1'b0, KIND_EXACT, 16'sh7fff, 8'd255));
    issue(lookup_cmd(1'b0, 16'sd0, 16'sd0, 8'd255));
    issue(lookup_cmd(1'b1, 16'sd0, 16'sd0, 8'd0));

    // Lower bound: hits only when eval reaches beta and the depth is enough.
    issue(store_cmd(1'b1, KIND_LOWER, 16'sh8000, 8'd0));
    maybe_idle(1'b1);
    issue(lookup_cmd(1'b1, 16'sd0, 16'sh8000, 8'd0));
    issue(lookup_cmd(1'b1, 16'sd0, 16'sh8001, 8'd0));
    issue(lookup_cmd(1'b1, 16'sd0, 16'sh8000, 8'd1));

    // Undo a move, then an upper bound at and just above alpha.
    issue(toggle_cmd(sq_b));
    issue(store_cmd(1'b0, KIND_UPPER, 16'sd100, 8'd5));
    issue(lookup_cmd(1'b0, 16'sd100, 16'sd0, 8'd5));
    issue(lookup_cmd(1'b0, 16'sd99, 16'sd0, 8'd5));

    // An entry of the unused kind never hits.
    issue(store_cmd(1'b1, KIND_NONE, 16'sd0, 8'd255));
    issue(lookup_cmd(1'b1, 16'sd0, 16'sd0, 8'd0));

    // Same slot, different checksum: the lookup must miss.
    issue(load_cmd(sq_c, 32'habcd_e000, {$urandom, $urandom} | 64'd1));
    issue(store_cmd(1'b0, KIND_EXACT, 16'sd7, 8'd0));
    issue(toggle_cmd(sq_c));
    issue(lookup_cmd(1'b0, 16'sd0, 16'sd0, 8'd0));
    issue(noise_cmd(CMD_CLEAR));

    // Random part; one stretch in the middle and the tail run without gaps.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      maybe_idle(n < RANDOM_ITEMS - CALM_ITEMS && !(n >= 400 && n < 500));
      random_step();
    end
    start <= 1'b0;

    // Let the outstanding answers arrive, then a few more cycles for strays.
    while (mirror.pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mirror.failures == 0 && mirror.pending_answers.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/ztt_pkg.sv
src/ztt_ctrl.sv
src/ztt_dpath.sv
src/zobrist_transposition_table.sv
tb/testbench.sv
